// ===== rtl/spt_pkg.sv =====
// Shared types, codes and arithmetic helpers for the sparse polynomial term table.
package spt_pkg;

  localparam int MAX_TERMS = 16;
  localparam int COEF_W    = 32;  // signed Q16.16
  localparam int EXP_W     = 16;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int SUM_W     = COEF_W + 2;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [EXP_W-1:0]  exp_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic [2:0] {
    REQ_INS_A = 3'd0,
    REQ_INS_B = 3'd1,
    REQ_ADD   = 3'd2,
    REQ_SUB   = 3'd3,
    REQ_CLR_A = 3'd4,
    REQ_CLR_B = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ST_TERM      = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_MERGED    = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_ZERO_IGN  = 3'd4,
    ST_FULL      = 3'd5,
    ST_ZERO_POLY = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CMP,
    OP_INS,
    OP_DEL,
    OP_UPD,
    OP_ROT,
    OP_CLR
  } op_t;

  typedef struct packed {
    coef_t coef;
    exp_t  exp;
  } term_t;

  typedef struct packed {
    op_t   op;
    coef_t coef;
    exp_t  exp;
  } tbl_cmd_t;

  function automatic sum_t ext_coef(input coef_t c);
    ext_coef = {{2{c[COEF_W-1]}}, c};
  endfunction

  // Clamp an exact sum to the signed coefficient range.
  function automatic coef_t sat_coef(input sum_t v);
    logic [2:0] top;
    top = v[SUM_W-1:COEF_W-1];
    if (top == 3'b000 || top == 3'b111) begin
      sat_coef = v[COEF_W-1:0];
    end else if (v[SUM_W-1]) begin
      sat_coef = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      sat_coef = {1'b0, {(COEF_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/spt_cell.sv =====
// One term slot of a table chain: holds a term and its compare flags.
module spt_cell import spt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tbl_cmd_t cmd,
  input  logic     active,
  input  logic     wrap,
  input  logic     left_lt,
  input  term_t    left_term,
  input  term_t    right_term,
  input  term_t    wrap_term,
  output term_t    term_o,
  output logic     lt_o,
  output logic     eq_o
);

  term_t term_r, term_nxt;
  logic  lt_r, lt_nxt;
  logic  eq_r, eq_nxt;

  always_comb begin
    term_nxt = term_r;
    lt_nxt   = lt_r;
    eq_nxt   = eq_r;
    case (cmd.op)
      OP_CMP: begin
        lt_nxt = active && ($signed(term_r.exp) < $signed(cmd.exp));
        eq_nxt = active && (term_r.exp == cmd.exp);
      end
      OP_INS: begin
        // the first cell at or after the slot takes the new term, the rest shift up
        if (!lt_r) begin
          term_nxt = left_lt ? term_t'{coef: cmd.coef, exp: cmd.exp} : left_term;
        end
      end
      OP_DEL: begin
        if (!lt_r) begin
          term_nxt = right_term;
        end
      end
      OP_UPD: begin
        if (eq_r) begin
          term_nxt = term_t'{coef: cmd.coef, exp: cmd.exp};
        end
      end
      OP_ROT: begin
        term_nxt = wrap ? wrap_term : right_term;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
  end

  assign term_o = term_r;
  assign lt_o   = lt_r;
  assign eq_o   = eq_r;

endmodule

// ===== rtl/spt_table.sv =====
// Term table: a chain of cells kept in ascending exponent order plus its term count.
module spt_table import spt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tbl_cmd_t cmd,
  output term_t    head,
  output cnt_t     count,
  output logic     found,
  output coef_t    match_coef
);

  term_t term_w [MAX_TERMS];
  logic  lt_w   [MAX_TERMS];
  logic  eq_w   [MAX_TERMS];
  cnt_t  cnt_r, cnt_nxt;

  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    logic  left_lt;
    term_t left_term;
    term_t right_term;

    if (i == 0) begin : g_first
      assign left_lt   = 1'b1;
      assign left_term = term_w[0];
    end else begin : g_mid
      assign left_lt   = lt_w[i-1];
      assign left_term = term_w[i-1];
    end

    if (i == MAX_TERMS - 1) begin : g_last
      assign right_term = term_w[i];
    end else begin : g_inner
      assign right_term = term_w[i+1];
    end

    spt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .active     (cnt_t'(i) < cnt_r),
      .wrap       (cnt_t'(i) == cnt_r - 1'b1),
      .left_lt    (left_lt),
      .left_term  (left_term),
      .right_term (right_term),
      .wrap_term  (term_w[0]),
      .term_o     (term_w[i]),
      .lt_o       (lt_w[i]),
      .eq_o       (eq_w[i])
    );
  end

  // At most one cell matches, so an OR picks its coefficient.
  always_comb begin
    match_coef = '0;
    found      = 1'b0;
    for (int i = 0; i < MAX_TERMS; i++) begin
      if (eq_w[i]) begin
        match_coef = match_coef | term_w[i].coef;
      end
      found = found | eq_w[i];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    case (cmd.op)
      OP_INS:  cnt_nxt = cnt_r + 1'b1;
      OP_DEL:  cnt_nxt = cnt_r - 1'b1;
      OP_CLR:  cnt_nxt = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head  = term_w[0];
  assign count = cnt_r;

endmodule

// ===== rtl/sparse_polynomial_term_table.sv =====
// Top level: request sequencer, merge adder and result register over two term chains.
//
// Holds polynomials A and B, up to 16 terms each, as chains of cells in ascending
// exponent order. An insert presents its single result beat (a zero coefficient
// goes straight to it) after these steps: compare in every cell, form the
// saturated sum, then update the matched term in place or shift the chain one
// cell to open or close a slot, unless the chain is full. Add and subtract walk
// both chains through one shared merge adder, rotating the head term out of each
// chain one per cycle while the output register can take a beat; a pair of equal
// exponents leaves both chains at once. The chains are back in order at the end.
// Clear takes effect at once and gives no beat. A new request is taken only
// when the previous one is done; a finished beat may still wait in the output
// register while the next request starts.
module sparse_polynomial_term_table import spt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] term_coef, [47:32] term_exp
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] out_coef, [47:32] out_exp
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_ADD,
    S_APPLY,
    S_RESP,
    S_MERGE
  } state_t;

  state_t  state_r, state_nxt;
  coef_t   req_coef_r, req_coef_nxt;
  exp_t    req_exp_r, req_exp_nxt;
  logic    tgt_b_r, tgt_b_nxt;
  logic    sub_r, sub_nxt;
  status_t status_r, status_nxt;
  coef_t   sum_r, sum_nxt;
  logic    found_r, found_nxt;
  cnt_t    ia_r, ia_nxt;
  cnt_t    ib_r, ib_nxt;
  logic    pend_v_r, pend_v_nxt;
  term_t   pend_r, pend_nxt;
  logic    out_valid_r, out_valid_nxt;
  term_t   out_term_r, out_term_nxt;
  status_t out_status_r, out_status_nxt;
  logic    out_last_r, out_last_nxt;

  tbl_cmd_t cmd_a, cmd_b;
  term_t    head_a, head_b;
  cnt_t     cnt_a, cnt_b;
  logic     found_a, found_b;
  coef_t    match_a, match_b;

  spt_table u_tbl_a (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd_a),
    .head       (head_a),
    .count      (cnt_a),
    .found      (found_a),
    .match_coef (match_a)
  );

  spt_table u_tbl_b (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd_b),
    .head       (head_b),
    .count      (cnt_b),
    .found      (found_b),
    .match_coef (match_b)
  );

  logic  in_acc;
  logic  out_free;
  req_t  req;
  coef_t in_coef;
  exp_t  in_exp;
  logic  take_a, take_b;
  sum_t  a_op, b_ext, b_op;
  coef_t m_coef;
  exp_t  m_exp;
  cnt_t  tgt_cnt;
  op_t   tgt_op;
  coef_t tgt_coef;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign req       = req_t'(in_tuser);
  assign in_coef   = in_tdata[31:0];
  assign in_exp    = in_tdata[47:32];
  assign tgt_cnt   = tgt_b_r ? cnt_b : cnt_a;

  // Merge step on the two chain heads.
  always_comb begin
    take_a = (ia_r != '0) && ((ib_r == '0) || ($signed(head_a.exp) < $signed(head_b.exp)));
    take_b = (ib_r != '0) && ((ia_r == '0) || ($signed(head_b.exp) < $signed(head_a.exp)));
    a_op   = take_b ? sum_t'(0) : ext_coef(head_a.coef);
    b_ext  = ext_coef(head_b.coef);
    b_op   = take_a ? sum_t'(0) : (sub_r ? -b_ext : b_ext);
    m_coef = sat_coef(a_op + b_op);
    m_exp  = take_b ? head_b.exp : head_a.exp;
  end

  always_comb begin
    state_nxt      = state_r;
    req_coef_nxt   = req_coef_r;
    req_exp_nxt    = req_exp_r;
    tgt_b_nxt      = tgt_b_r;
    sub_nxt        = sub_r;
    status_nxt     = status_r;
    sum_nxt        = sum_r;
    found_nxt      = found_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_term_nxt   = out_term_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    tgt_op         = OP_HOLD;
    tgt_coef       = req_coef_r;
    cmd_a          = tbl_cmd_t'{op: OP_HOLD, coef: req_coef_r, exp: req_exp_r};
    cmd_b          = tbl_cmd_t'{op: OP_HOLD, coef: req_coef_r, exp: req_exp_r};

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (req)
            REQ_INS_A, REQ_INS_B: begin
              req_coef_nxt = in_coef;
              req_exp_nxt  = in_exp;
              tgt_b_nxt    = (req == REQ_INS_B);
              if (in_coef == '0) begin
                status_nxt = ST_ZERO_IGN;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_CMP;
              end
            end
            REQ_ADD, REQ_SUB: begin
              sub_nxt    = (req == REQ_SUB);
              ia_nxt     = cnt_a;
              ib_nxt     = cnt_b;
              pend_v_nxt = 1'b0;
              state_nxt  = S_MERGE;
            end
            REQ_CLR_A: cmd_a.op = OP_CLR;
            REQ_CLR_B: cmd_b.op = OP_CLR;
            default: ;
          endcase
        end
      end
      S_CMP: begin
        tgt_op    = OP_CMP;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        sum_nxt   = sat_coef(ext_coef(tgt_b_r ? match_b : match_a) + ext_coef(req_coef_r));
        found_nxt = tgt_b_r ? found_b : found_a;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (found_r) begin
          if (sum_r == '0) begin
            tgt_op     = OP_DEL;
            status_nxt = ST_CANCELLED;
          end else begin
            tgt_op     = OP_UPD;
            tgt_coef   = sum_r;
            status_nxt = ST_MERGED;
          end
        end else if (tgt_cnt == cnt_t'(MAX_TERMS)) begin
          status_nxt = ST_FULL;
        end else begin
          tgt_op     = OP_INS;
          status_nxt = ST_INSERTED;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_term_nxt   = term_t'{coef: '0, exp: '0};
          out_status_nxt = status_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_MERGE: begin
        if (out_free) begin
          if (ia_r != '0 || ib_r != '0) begin
            if (!take_b) begin
              cmd_a.op = OP_ROT;
              ia_nxt   = ia_r - 1'b1;
            end
            if (!take_a) begin
              cmd_b.op = OP_ROT;
              ib_nxt   = ib_r - 1'b1;
            end
            // hold one term back so the final one can carry tlast
            if (m_coef != '0) begin
              if (pend_v_r) begin
                out_valid_nxt  = 1'b1;
                out_term_nxt   = pend_r;
                out_status_nxt = ST_TERM;
                out_last_nxt   = 1'b0;
              end
              pend_v_nxt = 1'b1;
              pend_nxt   = term_t'{coef: m_coef, exp: m_exp};
            end
          end else begin
            out_valid_nxt  = 1'b1;
            out_last_nxt   = 1'b1;
            if (pend_v_r) begin
              out_term_nxt   = pend_r;
              out_status_nxt = ST_TERM;
            end else begin
              out_term_nxt   = term_t'{coef: '0, exp: '0};
              out_status_nxt = ST_ZERO_POLY;
            end
            pend_v_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (state_r == S_CMP || state_r == S_APPLY) begin
      if (tgt_b_r) begin
        cmd_b.op   = tgt_op;
        cmd_b.coef = tgt_coef;
      end else begin
        cmd_a.op   = tgt_op;
        cmd_a.coef = tgt_coef;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_coef_r   <= req_coef_nxt;
    req_exp_r    <= req_exp_nxt;
    tgt_b_r      <= tgt_b_nxt;
    sub_r        <= sub_nxt;
    status_r     <= status_nxt;
    sum_r        <= sum_nxt;
    found_r      <= found_nxt;
    ia_r         <= ia_nxt;
    ib_r         <= ib_nxt;
    pend_r       <= pend_nxt;
    out_term_r   <= out_term_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_term_r.exp, out_term_r.coef};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/spt_checker.sv =====
// Port-level checks for the sparse polynomial term table, bound to the top level.
module spt_checker import spt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Status beats stand alone: each closes its request.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_TERM |-> out_tlast)
    else $error("status beat without tlast");

  // Status beats carry no term.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_TERM |-> out_tdata == '0)
    else $error("status beat with nonzero data");

  // An accepted insert keeps the input closed while the chain is updated.
  a_ins_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == REQ_INS_A || in_tuser == REQ_INS_B)
      |=> !in_tready)
    else $error("input taken during insert");

endmodule

bind sparse_polynomial_term_table spt_checker u_spt_checker (.*);
